[rtl/cmpj_pkg.sv]
// Shared types and constants of the cone-matching block.
// No dependencies; every other file of the block imports this package.
package cmpj_pkg;

	// Jet table depth and the widths that follow from it
	localparam int MAX_JETS = 64;
	localparam int CNT_W    = $clog2(MAX_JETS + 1);
	localparam int IDX_W    = (MAX_JETS > 1) ? $clog2(MAX_JETS) : 1;

	// Field widths
	localparam int PT_W      = 24;
	localparam int ANG_W     = 16;
	localparam int DIFF_W    = ANG_W + 1;
	localparam int MAG_W     = 16;
	localparam int SQ_W      = 2 * MAG_W;
	localparam int DR_W      = SQ_W + 1;
	localparam int CONE_W    = 32;
	localparam int JIDX_W    = 6;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;

	// Azimuth wrap limits in units of 1/8192 rad
	localparam logic signed [DIFF_W-1:0] PHI_PI     = 17'sd25736;
	localparam logic signed [DIFF_W-1:0] PHI_TWO_PI = 17'sd51472;

	// Register reset values
	localparam logic [PT_W-1:0]   PARTICLE_PT_MIN_RST = 24'd5000;
	localparam logic [PT_W-1:0]   JET_PT_MIN_RST      = 24'd10000;
	localparam logic [CONE_W-1:0] CONE_RADIUS_SQ_RST  = 32'd6039797;

	// Last drain count of the distance unit behind the last table read
	localparam logic [1:0] DRAIN_LAST = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PARTICLE_PT_MIN = 2'd0,
		REG_JET_PT_MIN      = 2'd1,
		REG_CONE_RADIUS_SQ  = 2'd2,
		REG_MATCH_MODE      = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		REQ_LOAD  = 1'b0,
		REQ_QUERY = 1'b1
	} req_t;

	typedef enum logic {
		MODE_MIN_DR = 1'b0,
		MODE_MAX_PT = 1'b1
	} match_mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [PT_W-1:0]         pt;
		logic signed [ANG_W-1:0] eta;
		logic signed [ANG_W-1:0] phi;
	} jet_t;

	typedef struct packed {
		logic             clear;
		logic             feed;
		logic [IDX_W-1:0] idx;
	} scan_ctl_t;

	typedef struct packed {
		logic             dr_found;
		logic [IDX_W-1:0] dr_idx;
		logic             pt_found;
		logic [IDX_W-1:0] pt_idx;
	} scan_res_t;

endpackage

[rtl/cmpj_item_if.sv]
// Input channel of the cone-matching block: jet loads and particle queries.
// Depends on cmpj_pkg for field widths.
interface cmpj_item_if;
	import cmpj_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    req_type;
	logic                    new_event;
	logic [PT_W-1:0]         item_pt;
	logic signed [ANG_W-1:0] item_eta;
	logic signed [ANG_W-1:0] item_phi;

	modport source (output valid, req_type, new_event, item_pt, item_eta, item_phi,
		input ready);
	modport sink (input valid, req_type, new_event, item_pt, item_eta, item_phi,
		output ready);
endinterface

[rtl/cmpj_result_if.sv]
// Output channel of the cone-matching block: one result beat per input beat.
// Depends on cmpj_pkg for field widths.
interface cmpj_result_if;
	import cmpj_pkg::*;

	logic              valid;
	logic              ready;
	logic              matched;
	logic [JIDX_W-1:0] jet_index;
	logic              table_full;

	modport source (output valid, matched, jet_index, table_full, input ready);
	modport sink (input valid, matched, jet_index, table_full, output ready);
endinterface

[rtl/cone_match_particle_to_jet_core.sv]
// Cone matching of a particle to a table of jets held in a rotating ring of cells.
// Load beat: the result is registered in the cycle after acceptance; one load per
// cycle while the output is free. Query beat: the ring rotates every jet through
// the distance pipeline, which then drains; one query at a time.
// Reset clears the jet count, the registers to their defaults and the output beat.
// Depends on cmpj_pkg, cmpj_item_if, cmpj_result_if, cmpj_cell and cmpj_scan.
module cone_match_particle_to_jet_core (
	input  logic                              clk,
	input  logic                              arst_n,
	cmpj_item_if.sink                         item,
	cmpj_result_if.source                     result,
	input  logic                              cfg_we,
	input  logic [cmpj_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [cmpj_pkg::CFG_W-1:0]        cfg_data
);
	import cmpj_pkg::*;

	logic [PT_W-1:0]   particle_pt_min_q;
	logic [PT_W-1:0]   jet_pt_min_q;
	logic [CONE_W-1:0] cone_q;
	match_mode_t       mode_q;

	state_t            state_q;
	state_t            state_d;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  scan_q;
	logic [1:0]        drain_q;
	logic signed [ANG_W-1:0] part_eta_q;
	logic signed [ANG_W-1:0] part_phi_q;
	logic              pt_ok_q;

	logic              out_v_q;
	logic              matched_q;
	logic [JIDX_W-1:0] jet_index_q;
	logic              table_full_q;

	logic              in_ready;
	logic              shift_en;
	logic              done_wr;
	logic              accept;
	logic              load_acc;
	logic              query_acc;
	logic              full_drop;
	logic              load_we;
	logic [CNT_W-1:0]  wr_addr;
	logic              scan_last;

	jet_t              wr_jet;
	jet_t              cells [MAX_JETS];
	scan_ctl_t         ctl;
	scan_res_t         res;

	logic              sel_found;
	logic [IDX_W-1:0]  sel_idx;
	logic [IDX_W+JIDX_W-1:0] sel_wide;
	logic              res_matched;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			particle_pt_min_q <= PARTICLE_PT_MIN_RST;
			jet_pt_min_q      <= JET_PT_MIN_RST;
			cone_q            <= CONE_RADIUS_SQ_RST;
			mode_q            <= MODE_MIN_DR;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_PARTICLE_PT_MIN: particle_pt_min_q <= cfg_data[PT_W-1:0];
				REG_JET_PT_MIN:      jet_pt_min_q      <= cfg_data[PT_W-1:0];
				REG_CONE_RADIUS_SQ:  cone_q            <= cfg_data[CONE_W-1:0];
				REG_MATCH_MODE:      mode_q            <= match_mode_t'(cfg_data[0]);
			endcase
		end
	end

	// Handshake decode
	assign accept    = item.valid && in_ready;
	assign load_acc  = accept && (item.req_type == REQ_LOAD);
	assign query_acc = accept && (item.req_type == REQ_QUERY);
	assign full_drop = !item.new_event && (count_q == CNT_W'(MAX_JETS));
	assign load_we   = load_acc && !full_drop;
	assign wr_addr   = item.new_event ? '0 : count_q;
	assign scan_last = (scan_q == CNT_W'(MAX_JETS - 1));

	assign wr_jet.pt  = item.item_pt;
	assign wr_jet.eta = item.item_eta;
	assign wr_jet.phi = item.item_phi;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (query_acc) state_d = ST_SCAN;
			ST_SCAN:  if (scan_last) state_d = ST_DRAIN;
			ST_DRAIN: if (drain_q == DRAIN_LAST) state_d = ST_DONE;
			ST_DONE:  if (!out_v_q || result.ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		in_ready = 1'b0;
		shift_en = 1'b0;
		done_wr  = 1'b0;
		unique case (state_q)
			ST_IDLE:  in_ready = !out_v_q || result.ready;
			ST_SCAN:  shift_en = 1'b1;
			ST_DRAIN: ;
			ST_DONE:  done_wr = !out_v_q || result.ready;
			default:  ;
		endcase
	end

	assign item.ready = in_ready;

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			scan_q  <= '0;
			drain_q <= '0;
			pt_ok_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_we) begin
				count_q <= wr_addr + CNT_W'(1);
			end
			if (query_acc) begin
				scan_q  <= '0;
				pt_ok_q <= (item.item_pt >= particle_pt_min_q);
			end else if (shift_en && !scan_last) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			if (state_q != ST_DRAIN) begin
				drain_q <= '0;
			end else begin
				drain_q <= drain_q + 2'd1;
			end
		end
	end

	// Hold the particle position for the whole scan
	always_ff @(posedge clk) begin
		if (query_acc) begin
			part_eta_q <= item.item_eta;
			part_phi_q <= item.item_phi;
		end
	end

	// Ring of jet cells; cell 0 presents jet scan_q to the distance pipeline
	for (genvar i = 0; i < MAX_JETS; i++) begin : g_cell
		cmpj_cell u_cell (
			.clk     (clk),
			.we      (load_we && (wr_addr == CNT_W'(i))),
			.wr_jet  (wr_jet),
			.shift   (shift_en),
			.nxt_jet (cells[(i + 1) % MAX_JETS]),
			.jet_q   (cells[i])
		);
	end

	assign ctl.clear = query_acc;
	assign ctl.feed  = shift_en && (scan_q < count_q);
	assign ctl.idx   = scan_q[IDX_W-1:0];

	cmpj_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.jet        (cells[0]),
		.part_eta   (part_eta_q),
		.part_phi   (part_phi_q),
		.jet_pt_min (jet_pt_min_q),
		.cone       (cone_q),
		.res        (res)
	);

	// Pick the answer of the active mode
	always_comb begin
		if (mode_q == MODE_MAX_PT) begin
			sel_found = res.pt_found;
			sel_idx   = res.pt_idx;
		end else begin
			sel_found = res.dr_found;
			sel_idx   = res.dr_idx;
		end
		res_matched = pt_ok_q && sel_found;
		sel_wide    = {{JIDX_W{1'b0}}, sel_idx};
	end

	// Output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load_acc || done_wr) begin
			out_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_acc) begin
			matched_q    <= 1'b0;
			jet_index_q  <= '0;
			table_full_q <= full_drop;
		end else if (done_wr) begin
			matched_q    <= res_matched;
			jet_index_q  <= res_matched ? sel_wide[JIDX_W-1:0] : '0;
			table_full_q <= 1'b0;
		end
	end

	assign result.valid      = out_v_q;
	assign result.matched    = matched_q;
	assign result.jet_index  = jet_index_q;
	assign result.table_full = table_full_q;

	// A load beat is answered in the next cycle
	a_load_answer: assert property (@(posedge clk) disable iff (!arst_n)
		load_acc |=> out_v_q)
		else $error("load beat not answered");

	// The jet count does not change during the scan and drain states
	a_count_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_DRAIN) |=> $stable(count_q))
		else $error("jet count changed during a scan");

	// The jet count never exceeds the table depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_JETS))
		else $error("jet count beyond table depth");

	// A query starts the scan from the first table entry
	a_query_start: assert property (@(posedge clk) disable iff (!arst_n)
		query_acc |=> (state_q == ST_SCAN) && (scan_q == '0))
		else $error("query did not start a scan");
endmodule

[rtl/cmpj_cell.sv]
// One jet slot of the rotating jet table.
// Depends on cmpj_pkg for the jet record type.
module cmpj_cell (
	input  logic            clk,
	input  logic            we,
	input  cmpj_pkg::jet_t  wr_jet,
	input  logic            shift,
	input  cmpj_pkg::jet_t  nxt_jet,
	output cmpj_pkg::jet_t  jet_q
);
	import cmpj_pkg::*;

	// Write a loaded jet, or take the neighbor's jet while the ring rotates
	always_ff @(posedge clk) begin
		if (we) begin
			jet_q <= wr_jet;
		end else if (shift) begin
			jet_q <= nxt_jet;
		end
	end
endmodule

[rtl/cmpj_scan.sv]
// Distance and selection pipeline fed by the head cell of the jet ring.
// Depends on cmpj_pkg for types, widths and the azimuth wrap constants.
module cmpj_scan (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cmpj_pkg::scan_ctl_t             ctl,
	input  cmpj_pkg::jet_t                  jet,
	input  logic signed [cmpj_pkg::ANG_W-1:0] part_eta,
	input  logic signed [cmpj_pkg::ANG_W-1:0] part_phi,
	input  logic [cmpj_pkg::PT_W-1:0]       jet_pt_min,
	input  logic [cmpj_pkg::CONE_W-1:0]     cone,
	output cmpj_pkg::scan_res_t             res
);
	import cmpj_pkg::*;

	logic signed [DIFF_W-1:0] deta;
	logic signed [DIFF_W-1:0] dphi_raw;
	logic signed [DIFF_W-1:0] dphi;
	logic                     elig;

	logic                     v_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic [PT_W-1:0]          pt_s1;
	logic signed [DIFF_W-1:0] deta_s1;
	logic signed [DIFF_W-1:0] dphi_s1;

	logic [DIFF_W-1:0]        eta_mag;
	logic [DIFF_W-1:0]        phi_mag;

	logic                     v_s2;
	logic [IDX_W-1:0]         idx_s2;
	logic [PT_W-1:0]          pt_s2;
	logic [SQ_W-1:0]          sq_eta_s2;
	logic [SQ_W-1:0]          sq_phi_s2;

	logic [DR_W-1:0]          dr;

	logic                     v_s3;
	logic [IDX_W-1:0]         idx_s3;
	logic [PT_W-1:0]          pt_s3;
	logic [DR_W-1:0]          dr_s3;

	logic                     dr_found_q;
	logic [DR_W-1:0]          best_dr_q;
	logic [IDX_W-1:0]         dr_idx_q;
	logic                     pt_found_q;
	logic [PT_W-1:0]          best_pt_q;
	logic [IDX_W-1:0]         pt_idx_q;

	// Stage 1: differences, azimuth wrap, jet pT cut
	always_comb begin
		deta     = DIFF_W'(jet.eta) - DIFF_W'(part_eta);
		dphi_raw = DIFF_W'(jet.phi) - DIFF_W'(part_phi);
		if (dphi_raw > PHI_PI) begin
			dphi = dphi_raw - PHI_TWO_PI;
		end else if (dphi_raw < -PHI_PI) begin
			dphi = dphi_raw + PHI_TWO_PI;
		end else begin
			dphi = dphi_raw;
		end
		elig = ctl.feed && (jet.pt >= jet_pt_min);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= elig;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= ctl.idx;
		pt_s1   <= jet.pt;
		deta_s1 <= deta;
		dphi_s1 <= dphi;
	end

	// Stage 2: magnitudes and squares
	always_comb begin
		eta_mag = deta_s1[DIFF_W-1] ? DIFF_W'(-deta_s1) : DIFF_W'(deta_s1);
		phi_mag = dphi_s1[DIFF_W-1] ? DIFF_W'(-dphi_s1) : DIFF_W'(dphi_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s2    <= idx_s1;
		pt_s2     <= pt_s1;
		sq_eta_s2 <= SQ_W'(eta_mag[MAG_W-1:0]) * SQ_W'(eta_mag[MAG_W-1:0]);
		sq_phi_s2 <= SQ_W'(phi_mag[MAG_W-1:0]) * SQ_W'(phi_mag[MAG_W-1:0]);
	end

	// Stage 3: squared distance and cone cut
	assign dr = DR_W'(sq_eta_s2) + DR_W'(sq_phi_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2 && (dr <= DR_W'(cone));
		end
	end

	always_ff @(posedge clk) begin
		idx_s3 <= idx_s2;
		pt_s3  <= pt_s2;
		dr_s3  <= dr;
	end

	// Keep the closest and the hardest jet; the earlier index holds on ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dr_found_q <= 1'b0;
			pt_found_q <= 1'b0;
			best_pt_q  <= '0;
		end else if (ctl.clear) begin
			dr_found_q <= 1'b0;
			pt_found_q <= 1'b0;
			best_pt_q  <= '0;
		end else if (v_s3) begin
			if (!dr_found_q || (dr_s3 < best_dr_q)) begin
				dr_found_q <= 1'b1;
			end
			if (pt_s3 > best_pt_q) begin
				pt_found_q <= 1'b1;
				best_pt_q  <= pt_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && !ctl.clear) begin
			if (!dr_found_q || (dr_s3 < best_dr_q)) begin
				best_dr_q <= dr_s3;
				dr_idx_q  <= idx_s3;
			end
			if (pt_s3 > best_pt_q) begin
				pt_idx_q <= idx_s3;
			end
		end
	end

	assign res.dr_found = dr_found_q;
	assign res.dr_idx   = dr_idx_q;
	assign res.pt_found = pt_found_q;
	assign res.pt_idx   = pt_idx_q;
endmodule

[tb/tb_top.sv]
// Self-checking testbench for cone_match_particle_to_jet_core: jet loads and particle
// queries with random gaps on both channels, checked against a behavioral matcher.
// Depends on cmpj_pkg, cmpj_item_if, cmpj_result_if and the core itself.
module tb_top;
	import cmpj_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int RESET_CYCLES = 7;
	localparam int BULK_ITEMS   = 1900;
	localparam int MAX_IDLE     = 5;
	localparam int PHI_RANGE    = 25736;

	typedef struct packed {
		req_t                    req;
		logic                    new_event;
		logic [PT_W-1:0]         pt;
		logic signed [ANG_W-1:0] eta;
		logic signed [ANG_W-1:0] phi;
	} beat_t;

	typedef struct packed {
		logic              matched;
		logic [JIDX_W-1:0] jet_index;
		logic              table_full;
	} match_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	cfg_reg_t             cfg_idx;
	logic [CFG_W-1:0]     cfg_data;

	cmpj_item_if   item_bus();
	cmpj_result_if result_bus();

	cone_match_particle_to_jet_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_bus),
		.result   (result_bus),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// Matcher state: jet table and register copies
	logic [PT_W-1:0] jet_pt_tab [MAX_JETS];
	int              jet_eta_tab [MAX_JETS];
	int              jet_phi_tab [MAX_JETS];
	int              jet_total = 0;
	logic [PT_W-1:0] lim_particle_pt = PARTICLE_PT_MIN_RST;
	logic [PT_W-1:0] lim_jet_pt = JET_PT_MIN_RST;
	longint          lim_cone = longint'(CONE_RADIUS_SQ_RST);
	match_mode_t     cur_mode = MODE_MIN_DR;

	// Traffic bookkeeping
	beat_t  pending_beats [$];
	match_t expected_matches [$];
	int     planned_eta [$];
	int     planned_phi [$];
	beat_t  taken_beat;
	beat_t  next_beat;
	match_t seen_match;
	match_t want_match;
	int     beats_queued = 0;
	int     beats_taken = 0;
	int     loads_taken = 0;
	int     queries_taken = 0;
	int     matches_seen = 0;
	int     drops_seen = 0;
	int     settings_applied = 0;
	int     errors = 0;
	int     idle_left = 0;
	int     stall_left = 0;
	int     hold_req = 0;
	int     hold_left = 0;
	int     cycle_count = 0;
	bit     steady = 1'b0;

	// Work out the result of one accepted beat and update the jet table
	function automatic match_t match_beat(beat_t b);
		match_t          r;
		int              p_eta;
		int              p_phi;
		int              deta;
		int              dphi;
		longint          dr2;
		longint          best_dist;
		logic [PT_W-1:0] best_pt;
		int              dist_idx;
		int              pt_idx;
		bit              dist_hit;
		bit              pt_hit;
		r = '0;
		p_eta = $signed(b.eta);
		p_phi = $signed(b.phi);
		if (b.req == REQ_LOAD) begin
			if (b.new_event)
				jet_total = 0;
			if (jet_total >= MAX_JETS) begin
				r.table_full = 1'b1;
			end else begin
				jet_pt_tab[jet_total] = b.pt;
				jet_eta_tab[jet_total] = p_eta;
				jet_phi_tab[jet_total] = p_phi;
				jet_total++;
			end
			return r;
		end
		if (b.pt < lim_particle_pt)
			return r;
		dist_hit = 1'b0;
		pt_hit = 1'b0;
		best_dist = 0;
		best_pt = '0;
		dist_idx = 0;
		pt_idx = 0;
		for (int i = 0; i < jet_total; i++) begin
			if (jet_pt_tab[i] < lim_jet_pt)
				continue;
			deta = jet_eta_tab[i] - p_eta;
			dphi = jet_phi_tab[i] - p_phi;
			while (dphi > int'(PHI_PI))
				dphi -= int'(PHI_TWO_PI);
			while (dphi < -int'(PHI_PI))
				dphi += int'(PHI_TWO_PI);
			dr2 = longint'(deta) * longint'(deta) + longint'(dphi) * longint'(dphi);
			if (dr2 > lim_cone)
				continue;
			if (!dist_hit || dr2 < best_dist) begin
				dist_hit = 1'b1;
				best_dist = dr2;
				dist_idx = i;
			end
			// strict compare keeps zero-pT jets out and the first index on ties
			if (jet_pt_tab[i] > best_pt) begin
				pt_hit = 1'b1;
				best_pt = jet_pt_tab[i];
				pt_idx = i;
			end
		end
		if (cur_mode == MODE_MIN_DR) begin
			if (dist_hit) begin
				r.matched = 1'b1;
				r.jet_index = dist_idx[JIDX_W-1:0];
			end
		end else if (pt_hit) begin
			r.matched = 1'b1;
			r.jet_index = pt_idx[JIDX_W-1:0];
		end
		return r;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Input side: offer queued beats, predict each accepted one, idle between beats
	always @(posedge clk) begin
		if (!arst_n) begin
			item_bus.valid <= 1'b0;
			item_bus.req_type <= REQ_LOAD;
			item_bus.new_event <= 1'b0;
			item_bus.item_pt <= '0;
			item_bus.item_eta <= '0;
			item_bus.item_phi <= '0;
		end else begin
			if (item_bus.valid && item_bus.ready) begin
				taken_beat.req = req_t'(item_bus.req_type);
				taken_beat.new_event = item_bus.new_event;
				taken_beat.pt = item_bus.item_pt;
				taken_beat.eta = item_bus.item_eta;
				taken_beat.phi = item_bus.item_phi;
				expected_matches = {expected_matches, match_beat(taken_beat)};
				beats_taken++;
				if (taken_beat.req == REQ_LOAD)
					loads_taken++;
				else
					queries_taken++;
				idle_left = steady ? 0 : $urandom_range(0, MAX_IDLE);
			end
			// hold a beat that is still waiting for ready
			if (!item_bus.valid || item_bus.ready) begin
				if (idle_left > 0) begin
					idle_left--;
					item_bus.valid <= 1'b0;
				end else if (pending_beats.size() != 0) begin
					next_beat = pending_beats.pop_front();
					item_bus.valid <= 1'b1;
					item_bus.req_type <= next_beat.req;
					item_bus.new_event <= next_beat.new_event;
					item_bus.item_pt <= next_beat.pt;
					item_bus.item_eta <= next_beat.eta;
					item_bus.item_phi <= next_beat.phi;
				end else begin
					item_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Output side: stall after each beat, or hold off for a long stretch on request
	always @(posedge clk) begin
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
		end else begin
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_bus.ready <= 1'b0;
			end else if (result_bus.valid && result_bus.ready) begin
				stall_left = steady ? 0 : $urandom_range(0, MAX_IDLE);
				result_bus.ready <= (stall_left == 0);
			end else if (stall_left > 0) begin
				stall_left--;
				result_bus.ready <= (stall_left == 0);
			end else begin
				result_bus.ready <= 1'b1;
			end
		end
	end

	// Compare each result beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready) begin
			seen_match.matched = result_bus.matched;
			seen_match.jet_index = result_bus.jet_index;
			seen_match.table_full = result_bus.table_full;
			if (expected_matches.size() == 0) begin
				$display("%0t: result beat with nothing expected: matched=%0d index=%0d full=%0d",
					$time, seen_match.matched, seen_match.jet_index, seen_match.table_full);
				errors++;
			end else begin
				want_match = expected_matches.pop_front();
				check_field("matched", want_match.matched, seen_match.matched);
				check_field("jet_index", want_match.jet_index, seen_match.jet_index);
				check_field("table_full", want_match.table_full, seen_match.table_full);
			end
			if (seen_match.matched)
				matches_seen++;
			if (seen_match.table_full)
				drops_seen++;
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	task automatic send_item(req_t req, logic new_event, logic [PT_W-1:0] pt,
		logic signed [ANG_W-1:0] eta, logic signed [ANG_W-1:0] phi);
		beat_t b;
		b.req = req;
		b.new_event = new_event;
		b.pt = pt;
		b.eta = eta;
		b.phi = phi;
		pending_beats = {pending_beats, b};
		beats_queued++;
	endtask

	// Wait until every queued beat is taken and every result has come back
	task automatic settle();
		while (pending_beats.size() != 0 || beats_taken != beats_queued ||
			expected_matches.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_PARTICLE_PT_MIN: lim_particle_pt = data[PT_W-1:0];
			REG_JET_PT_MIN:      lim_jet_pt = data[PT_W-1:0];
			REG_CONE_RADIUS_SQ:  lim_cone = longint'({32'd0, data[CONE_W-1:0]});
			default:             cur_mode = match_mode_t'(data[0]);
		endcase
		@(posedge clk);
	endtask

	task automatic apply_setting(logic [PT_W-1:0] pmin, logic [PT_W-1:0] jmin,
		logic [CONE_W-1:0] cone, match_mode_t mode);
		settle();
		write_reg(REG_PARTICLE_PT_MIN, CFG_W'(pmin));
		write_reg(REG_JET_PT_MIN, CFG_W'(jmin));
		write_reg(REG_CONE_RADIUS_SQ, CFG_W'(cone));
		write_reg(REG_MATCH_MODE, CFG_W'(mode));
		settings_applied++;
	endtask

	// pT around a threshold, at the extremes, or anywhere
	function automatic logic [PT_W-1:0] pick_pt(logic [PT_W-1:0] lim);
		case ($urandom_range(0, 5))
			0:       return lim;
			1:       return (lim == '0) ? '0 : lim - 1'b1;
			2:       return '0;
			3:       return '1;
			4:       return lim + PT_W'($urandom_range(0, 50000));
			default: return PT_W'($urandom);
		endcase
	endfunction

	// Angular offset from a stored jet: exact, inside, near or beyond the cone
	function automatic int nudge();
		case ($urandom_range(0, 3))
			0:       return 0;
			1:       return int'($urandom_range(0, 1000)) - 500;
			2:       return int'($urandom_range(0, 6000)) - 3000;
			default: return int'($urandom_range(0, 40000)) - 20000;
		endcase
	endfunction

	task automatic load_jet(logic new_event);
		logic signed [ANG_W-1:0] eta;
		logic signed [ANG_W-1:0] phi;
		if ($urandom_range(0, 3) == 0)
			eta = ANG_W'($urandom);
		else
			eta = ANG_W'(int'($urandom_range(0, 40000)) - 20000);
		if ($urandom_range(0, 5) == 0)
			phi = ANG_W'($urandom);
		else
			phi = ANG_W'(int'($urandom_range(0, 2 * PHI_RANGE)) - PHI_RANGE);
		if (new_event) begin
			planned_eta.delete();
			planned_phi.delete();
		end
		if (planned_eta.size() < MAX_JETS) begin
			planned_eta = {planned_eta, int'(eta)};
			planned_phi = {planned_phi, int'(phi)};
		end
		send_item(REQ_LOAD, new_event, pick_pt(lim_jet_pt), eta, phi);
	endtask

	// Mostly aim the particle at a jet of the current event
	task automatic query_near();
		int j;
		logic signed [ANG_W-1:0] eta;
		logic signed [ANG_W-1:0] phi;
		if (planned_eta.size() == 0 || $urandom_range(0, 3) == 0) begin
			eta = ANG_W'($urandom);
			phi = ANG_W'($urandom);
		end else begin
			j = $urandom_range(0, planned_eta.size() - 1);
			eta = ANG_W'(planned_eta[j] + nudge());
			phi = ANG_W'(planned_phi[j] + nudge());
		end
		send_item(REQ_QUERY, 1'($urandom), pick_pt(lim_particle_pt), eta, phi);
	endtask

	// One event: a fresh table, then loads and queries in random order
	task automatic run_event(int n_jets, int n_queries);
		int loads_left;
		int queries_left;
		loads_left = n_jets - 1;
		queries_left = n_queries;
		load_jet(1'b1);
		while (loads_left > 0 || queries_left > 0) begin
			if (queries_left == 0 || (loads_left > 0 && $urandom_range(0, 2) != 0)) begin
				load_jet(1'b0);
				loads_left--;
			end else begin
				query_near();
				queries_left--;
			end
		end
	endtask

	task automatic run_traffic(int n_items);
		int target;
		target = beats_queued + n_items;
		while (beats_queued < target) begin
			if ($urandom_range(0, 9) == 0)
				send_item(req_t'($urandom_range(0, 1)), 1'($urandom), PT_W'($urandom),
					ANG_W'($urandom), ANG_W'($urandom));
			else if ($urandom_range(0, 19) == 0)
				run_event($urandom_range(60, 70), $urandom_range(2, 6));
			else
				run_event($urandom_range(1, 10), $urandom_range(1, 8));
		end
	endtask

	// Field extremes, thresholds, cone edge, phi wrap, ties and zero-pT jets
	task automatic test_directed();
		send_item(REQ_QUERY, 1'b0, 24'hFFFFFF, 16'sd0, 16'sd0);
		send_item(REQ_LOAD, 1'b1, 24'hFFFFFF, 16'sh7FFF, 16'sd25736);
		send_item(REQ_LOAD, 1'b0, 24'd0, 16'sh8000, -16'sd25736);
		send_item(REQ_LOAD, 1'b0, 24'd10000, 16'sd0, 16'sd0);
		send_item(REQ_LOAD, 1'b0, 24'd9999, 16'sd0, 16'sd0);
		send_item(REQ_LOAD, 1'b0, 24'd20000, 16'sd0, 16'sd0);
		send_item(REQ_QUERY, 1'b0, 24'd4999, 16'sd0, 16'sd0);
		send_item(REQ_QUERY, 1'b1, 24'd5000, 16'sd0, 16'sd0);
		send_item(REQ_QUERY, 1'b0, 24'd5000, 16'sh7FFF, -16'sd25736);
		send_item(REQ_QUERY, 1'b0, 24'hFFFFFF, 16'sh8000, 16'sh8000);
		send_item(REQ_QUERY, 1'b0, 24'd6000, 16'sd2457, 16'sd0);
		send_item(REQ_QUERY, 1'b0, 24'd6000, 16'sd2458, 16'sd0);
		send_item(REQ_QUERY, 1'b0, 24'd6000, 16'sd0, 16'sh7FFF);
		apply_setting(PARTICLE_PT_MIN_RST, '0, CONE_RADIUS_SQ_RST, MODE_MAX_PT);
		send_item(REQ_QUERY, 1'b0, 24'd5000, 16'sd0, 16'sd0);
		send_item(REQ_LOAD, 1'b1, 24'd0, 16'sd100, 16'sd100);
		send_item(REQ_QUERY, 1'b0, 24'd5000, 16'sd100, 16'sd100);
		settle();
		write_reg(REG_MATCH_MODE, CFG_W'(MODE_MIN_DR));
		send_item(REQ_QUERY, 1'b0, 24'd5000, 16'sd100, 16'sd100);
		apply_setting(PARTICLE_PT_MIN_RST, JET_PT_MIN_RST, CONE_RADIUS_SQ_RST, MODE_MIN_DR);
	endtask

	// Fill the table, overflow it, then restart it with a new event
	task automatic test_table_full();
		load_jet(1'b1);
		repeat (MAX_JETS + 1)
			load_jet(1'b0);
		query_near();
		query_near();
		load_jet(1'b1);
		query_near();
		settle();
	endtask

	// Threshold and cone extremes in both modes
	task automatic test_setting_sweep();
		apply_setting('0, '0, '0, MODE_MIN_DR);
		run_traffic(120);
		apply_setting('0, '0, '0, MODE_MAX_PT);
		run_traffic(120);
		apply_setting('1, '1, '1, MODE_MAX_PT);
		run_traffic(120);
		apply_setting('1, '1, '1, MODE_MIN_DR);
		run_traffic(120);
		apply_setting('0, '0, '1, MODE_MAX_PT);
		run_traffic(120);
		apply_setting('0, JET_PT_MIN_RST, 32'd1, MODE_MIN_DR);
		run_traffic(120);
	endtask

	// Hold the result side off while the input keeps offering beats
	task automatic test_backpressure();
		apply_setting(PARTICLE_PT_MIN_RST, JET_PT_MIN_RST, CONE_RADIUS_SQ_RST, MODE_MAX_PT);
		hold_req = 400;
		run_event(20, 5);
		run_event(12, 3);
		settle();
	endtask

	// Back-to-back beats on both sides
	task automatic test_steady_flow();
		steady = 1'b1;
		run_traffic(150);
		settle();
		steady = 1'b0;
	endtask

	// Random settings, mostly near the reset values, until the item budget is spent
	task automatic test_random_mix();
		logic [CONE_W-1:0] cone;
		while (beats_queued < BULK_ITEMS) begin
			case ($urandom_range(0, 2))
				0:       cone = CONE_RADIUS_SQ_RST;
				1:       cone = CONE_W'($urandom_range(0, 20_000_000));
				default: cone = CONE_W'($urandom);
			endcase
			apply_setting(PT_W'($urandom_range(0, 20000)), PT_W'($urandom_range(0, 30000)),
				cone, match_mode_t'($urandom_range(0, 1)));
			run_traffic(200);
		end
	endtask

	// Reset, run the tests in turn, report
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_PARTICLE_PT_MIN;
		cfg_data = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_table_full();
		test_setting_sweep();
		test_backpressure();
		test_steady_flow();
		test_random_mix();
		settle();
		repeat (MAX_JETS + 8) @(posedge clk);
		if (expected_matches.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_matches.size());
			errors++;
		end
		$display("Ran %0d loads and %0d queries across %0d register settings",
			loads_taken, queries_taken, settings_applied);
		$display("%0d queries matched a jet, %0d loads hit a full table, %0d errors",
			matches_seen, drops_seen, errors);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
